@@ src/general_matrix_multiply_top_assert.svh @@
`ifndef GENERAL_MATRIX_MULTIPLY_TOP_ASSERT_SVH
`define GENERAL_MATRIX_MULTIPLY_TOP_ASSERT_SVH

// check a condition at every edge out of reset
`define GEMM_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("gemm check failed");

// check that a trigger implies a condition in the same cycle
`define GEMM_ASSERT_IMPL(lbl, trig, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error("gemm check failed");

`endif

@@ src/gemm_pkg.sv @@
`timescale 1ns / 1ps
package gemm_pkg;

    localparam int MAX_DIM  = 8;
    localparam int IDX_W    = 3;
    localparam int CNT_W    = 4;
    localparam int ELEM_W   = 16;
    localparam int ADDR_W   = $clog2(MAX_DIM * MAX_DIM);
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;

    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    localparam int PROD_W   = 2 * ELEM_W;
    localparam int SUM_W    = PROD_W + $clog2(MAX_DIM) + 1;
    localparam int SCALE_W  = SUM_W + ELEM_W;
    localparam int TOT_W    = SCALE_W + 1;
    localparam int OUT_W    = 32;
    localparam int FRAC_SH  = 16;

    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_ROW_COUNT    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_INNER_COUNT  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_COLUMN_COUNT = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ALPHA_GAIN   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_BETA_GAIN    = 3'd4;

    typedef enum logic [1:0] {
        ACT_WR_A    = 2'd0,
        ACT_WR_B    = 2'd1,
        ACT_WR_C    = 2'd2,
        ACT_COMPUTE = 2'd3
    } t_action;

    typedef struct packed {
        t_action                   action;
        logic [IDX_W-1:0]          row;
        logic [IDX_W-1:0]          col;
        logic signed [ELEM_W-1:0]  value;
    } t_cmd;

    typedef struct packed {
        logic                      valid;
        t_cmd                      cmd;
    } t_cmd_port;

    typedef struct packed {
        logic [IDX_W-1:0]          row;
        logic [IDX_W-1:0]          col;
        logic [OUT_W-1:0]          value;
        logic                      last;
    } t_result;

    typedef struct packed {
        logic                      full;
        logic [Q_CNT_W-1:0]        count;
    } t_front_status;

    typedef struct packed {
        logic                      busy;
        logic                      cmd_pop;
        logic [Q_CNT_W-1:0]        out_count;
    } t_back_status;

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = CNT_W'(1);
        end else if (v > CNT_W'(MAX_DIM)) begin
            r = CNT_W'(MAX_DIM);
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] row,
                                                    input logic [IDX_W-1:0] col);
        logic [ADDR_W-1:0] a;
        a = ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(col);
        return a;
    endfunction

    function automatic logic [OUT_W-1:0] shift_sat(input logic signed [TOT_W-1:0] acc);
        logic [TOT_W-FRAC_SH-1:0] q;
        logic [OUT_W-1:0]         r;
        q = acc[TOT_W-1:FRAC_SH];
        if (q[TOT_W-FRAC_SH-1:OUT_W-1] == '0 || q[TOT_W-FRAC_SH-1:OUT_W-1] == '1) begin
            r = q[OUT_W-1:0];
        end else if (q[TOT_W-FRAC_SH-1]) begin
            r = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(OUT_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

@@ src/general_matrix_multiply_top.sv @@
// Write items: queued on push while not full, stored when the back end pops them.
// Compute: each result element walks the shared multiply-accumulate sequencer
// (one store read, one multiply, one add per inner step), rows*cols elements.
// Rate: one write item per cycle when the back end is idle; a compute holds it for its walk.
// Reset (synchronous, active low): clears queues, sequencer and registers to their defaults.
// Store contents are not cleared and hold no value until written.
`timescale 1ns / 1ps
`include "general_matrix_multiply_top_assert.svh"
module general_matrix_multiply_top
    import gemm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [PDATA_W-1:0]       pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready,
    input  logic                     push,
    output logic                     full,
    input  logic [1:0]               i_action,
    input  logic [IDX_W-1:0]         i_row_index,
    input  logic [IDX_W-1:0]         i_col_index,
    input  logic signed [ELEM_W-1:0] i_elem_value,
    output logic                     empty,
    input  logic                     pop,
    output logic [IDX_W-1:0]         o_out_row,
    output logic [IDX_W-1:0]         o_out_col,
    output logic signed [OUT_W-1:0]  o_out_value,
    output logic                     o_last_flag
);

    logic [CNT_W-1:0]         r_row_count;
    logic [CNT_W-1:0]         r_inner_count;
    logic [CNT_W-1:0]         r_column_count;
    logic signed [ELEM_W-1:0] r_alpha_gain;
    logic signed [ELEM_W-1:0] r_beta_gain;
    logic                     cfg_wr;
    logic [REG_IDX_W-1:0]     reg_idx;
    t_cmd                     in_cmd;
    t_cmd_port                cmd_port;
    t_front_status            front_st;
    t_back_status             back_st;
    t_result                  result;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count    <= CNT_W'(8);
            r_inner_count  <= CNT_W'(8);
            r_column_count <= CNT_W'(8);
            r_alpha_gain   <= ELEM_W'(256);
            r_beta_gain    <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_ROW_COUNT:    r_row_count    <= pwdata[CNT_W-1:0];
                REG_INNER_COUNT:  r_inner_count  <= pwdata[CNT_W-1:0];
                REG_COLUMN_COUNT: r_column_count <= pwdata[CNT_W-1:0];
                REG_ALPHA_GAIN:   r_alpha_gain   <= pwdata[ELEM_W-1:0];
                REG_BETA_GAIN:    r_beta_gain    <= pwdata[ELEM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ROW_COUNT:    prdata = PDATA_W'(r_row_count);
            REG_INNER_COUNT:  prdata = PDATA_W'(r_inner_count);
            REG_COLUMN_COUNT: prdata = PDATA_W'(r_column_count);
            REG_ALPHA_GAIN:   prdata = PDATA_W'(r_alpha_gain);
            REG_BETA_GAIN:    prdata = PDATA_W'(r_beta_gain);
            default:          prdata = '0;
        endcase
    end

    assign in_cmd.action = t_action'(i_action);
    assign in_cmd.row    = i_row_index;
    assign in_cmd.col    = i_col_index;
    assign in_cmd.value  = i_elem_value;

    gemm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_cmd     (in_cmd),
        .i_cmd_pop (back_st.cmd_pop),
        .o_cmd     (cmd_port),
        .o_status  (front_st)
    );

    gemm_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd_port),
        .i_rows   (clamp_count(r_row_count)),
        .i_inner  (clamp_count(r_inner_count)),
        .i_cols   (clamp_count(r_column_count)),
        .i_alpha  (r_alpha_gain),
        .i_beta   (r_beta_gain),
        .i_pop    (pop),
        .o_result (result),
        .o_empty  (empty),
        .o_status (back_st)
    );

    assign full        = front_st.full;
    assign o_out_row   = result.row;
    assign o_out_col   = result.col;
    assign o_out_value = result.value;
    assign o_last_flag = result.last;

    `GEMM_ASSERT_ALWAYS(a_cmdq_bound, front_st.count <= Q_CNT_W'(Q_DEPTH))
    `GEMM_ASSERT_ALWAYS(a_outq_bound, back_st.out_count <= Q_CNT_W'(Q_DEPTH))
    `GEMM_ASSERT_IMPL(a_no_pop_busy, back_st.busy, !back_st.cmd_pop)
    `GEMM_ASSERT_IMPL(a_empty_match, empty, back_st.out_count == '0)

endmodule

@@ src/gemm_ram.sv @@
`timescale 1ns / 1ps
module gemm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [$clog2(DEPTH)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]          i_wdata,
    input  logic [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/gemm_front.sv @@
`timescale 1ns / 1ps
module gemm_front
    import gemm_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_cmd          i_cmd,
    input  logic          i_cmd_pop,
    output t_cmd_port     o_cmd,
    output t_front_status o_status
);

    t_cmd               r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr;
    logic [Q_PTR_W-1:0] r_rptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               full;
    logic               accept;
    logic               in_range;
    logic               enq;
    logic               deq;

    assign full     = (r_count == Q_CNT_W'(Q_DEPTH));
    assign accept   = i_push && !full;
    assign in_range = ({1'b0, i_cmd.row} < (IDX_W+1)'(MAX_DIM)) &&
                      ({1'b0, i_cmd.col} < (IDX_W+1)'(MAX_DIM));
    // drop writes that fall outside the stores
    assign enq      = accept && (i_cmd.action == ACT_COMPUTE || in_range);
    assign deq      = i_cmd_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_q[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (enq) begin
                r_wptr <= r_wptr + Q_PTR_W'(1);
            end
            if (deq) begin
                r_rptr <= r_rptr + Q_PTR_W'(1);
            end
            if (enq && !deq) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (deq && !enq) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

    assign o_cmd.valid     = (r_count != '0);
    assign o_cmd.cmd       = r_q[r_rptr];
    assign o_status.full   = full;
    assign o_status.count  = r_count;

endmodule

@@ src/gemm_back.sv @@
`timescale 1ns / 1ps
module gemm_back
    import gemm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd_port                i_cmd,
    input  logic [CNT_W-1:0]         i_rows,
    input  logic [CNT_W-1:0]         i_inner,
    input  logic [CNT_W-1:0]         i_cols,
    input  logic signed [ELEM_W-1:0] i_alpha,
    input  logic signed [ELEM_W-1:0] i_beta,
    input  logic                     i_pop,
    output t_result                  o_result,
    output logic                     o_empty,
    output t_back_status             o_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_MUL,
        S_ACC,
        S_SCALE,
        S_SUM,
        S_OUT
    } t_state;

    t_state                     r_state;
    logic [IDX_W-1:0]           r_i;
    logic [IDX_W-1:0]           r_j;
    logic [IDX_W-1:0]           r_k;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ELEM_W-1:0]   r_c;
    logic signed [SUM_W-1:0]    r_acc;
    logic signed [SCALE_W-1:0]  r_alpha_prod;
    logic signed [PROD_W-1:0]   r_beta_prod;
    logic signed [TOT_W-1:0]    r_total;

    logic                       cmd_pop;
    logic                       we_a;
    logic                       we_b;
    logic                       we_c;
    logic [ADDR_W-1:0]          waddr;
    logic signed [ELEM_W-1:0]   a_rdata;
    logic signed [ELEM_W-1:0]   b_rdata;
    logic signed [ELEM_W-1:0]   c_rdata;
    logic                       k_last;
    logic                       j_last;
    logic                       i_last;

    t_result                    r_oq [Q_DEPTH];
    logic [Q_PTR_W-1:0]         r_oq_wptr;
    logic [Q_PTR_W-1:0]         r_oq_rptr;
    logic [Q_CNT_W-1:0]         r_oq_count;
    logic                       oq_full;
    logic                       oq_push;
    logic                       oq_pop;
    t_result                    res;

    assign cmd_pop = (r_state == S_IDLE) && i_cmd.valid;
    assign waddr   = elem_addr(i_cmd.cmd.row, i_cmd.cmd.col);
    assign we_a    = cmd_pop && (i_cmd.cmd.action == ACT_WR_A);
    assign we_b    = cmd_pop && (i_cmd.cmd.action == ACT_WR_B);
    assign we_c    = cmd_pop && (i_cmd.cmd.action == ACT_WR_C);

    gemm_ram #(.WIDTH(ELEM_W), .DEPTH(STORE_DEPTH)) u_store_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (i_cmd.cmd.value),
        .i_raddr (elem_addr(r_i, r_k)),
        .o_rdata (a_rdata)
    );

    gemm_ram #(.WIDTH(ELEM_W), .DEPTH(STORE_DEPTH)) u_store_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (i_cmd.cmd.value),
        .i_raddr (elem_addr(r_k, r_j)),
        .o_rdata (b_rdata)
    );

    gemm_ram #(.WIDTH(ELEM_W), .DEPTH(STORE_DEPTH)) u_store_c (
        .i_clk   (i_clk),
        .i_we    (we_c),
        .i_waddr (waddr),
        .i_wdata (i_cmd.cmd.value),
        .i_raddr (elem_addr(r_i, r_j)),
        .o_rdata (c_rdata)
    );

    assign k_last  = (CNT_W'(r_k) == i_inner - CNT_W'(1));
    assign j_last  = (CNT_W'(r_j) == i_cols - CNT_W'(1));
    assign i_last  = (CNT_W'(r_i) == i_rows - CNT_W'(1));
    assign oq_full = (r_oq_count == Q_CNT_W'(Q_DEPTH));
    assign oq_push = (r_state == S_OUT) && !oq_full;
    assign oq_pop  = i_pop && (r_oq_count != '0);

    assign res.row   = r_i;
    assign res.col   = r_j;
    assign res.value = shift_sat(r_total);
    assign res.last  = i_last && j_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_acc   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (cmd_pop && i_cmd.cmd.action == ACT_COMPUTE) begin
                        r_i     <= '0;
                        r_j     <= '0;
                        r_k     <= '0;
                        r_acc   <= '0;
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= a_rdata * b_rdata;
                    r_c     <= c_rdata;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc <= r_acc + SUM_W'(r_prod);
                    if (k_last) begin
                        r_state <= S_SCALE;
                    end else begin
                        r_k     <= r_k + IDX_W'(1);
                        r_state <= S_FETCH;
                    end
                end
                S_SCALE: begin
                    r_alpha_prod <= SCALE_W'(i_alpha * r_acc);
                    r_beta_prod  <= i_beta * r_c;
                    r_state      <= S_SUM;
                end
                S_SUM: begin
                    r_total <= TOT_W'(r_alpha_prod) + (TOT_W'(r_beta_prod) <<< 8);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!oq_full) begin
                        r_k   <= '0;
                        r_acc <= '0;
                        if (j_last) begin
                            r_j <= '0;
                            r_i <= r_i + IDX_W'(1);
                        end else begin
                            r_j <= r_j + IDX_W'(1);
                        end
                        r_state <= (i_last && j_last) ? S_IDLE : S_FETCH;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (oq_push) begin
            r_oq[r_oq_wptr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wptr  <= '0;
            r_oq_rptr  <= '0;
            r_oq_count <= '0;
        end else begin
            if (oq_push) begin
                r_oq_wptr <= r_oq_wptr + Q_PTR_W'(1);
            end
            if (oq_pop) begin
                r_oq_rptr <= r_oq_rptr + Q_PTR_W'(1);
            end
            if (oq_push && !oq_pop) begin
                r_oq_count <= r_oq_count + Q_CNT_W'(1);
            end else if (oq_pop && !oq_push) begin
                r_oq_count <= r_oq_count - Q_CNT_W'(1);
            end
        end
    end

    assign o_result           = r_oq[r_oq_rptr];
    assign o_empty            = (r_oq_count == '0);
    assign o_status.busy      = (r_state != S_IDLE);
    assign o_status.cmd_pop   = cmd_pop;
    assign o_status.out_count = r_oq_count;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
    import gemm_pkg::*;

    localparam int STALL_LIMIT = 50000;

    class gemm_scoreboard;
        logic signed [15:0] mat[3][64];
        bit                 seen[3][64];
        logic [3:0]         rows_r, inner_r, cols_r;
        logic signed [15:0] alpha, beta;
        t_result            due_q[$];
        int                 errors;
        int                 checked;

        function void clear();
            foreach (seen[m, e]) begin
                seen[m][e] = 0;
                mat[m][e]  = '0;
            end
            rows_r = 4'd8;
            inner_r = 4'd8;
            cols_r = 4'd8;
            alpha = 16'sd256;
            beta = 16'sd0;
        endfunction

        function int eff(logic [3:0] v);
            if (v == 0) return 1;
            if (v > MAX_DIM) return MAX_DIM;
            return int'(v);
        endfunction

        function void set_reg(int idx, logic [31:0] d);
            case (idx)
                REG_ROW_COUNT:    rows_r = d[3:0];
                REG_INNER_COUNT:  inner_r = d[3:0];
                REG_COLUMN_COUNT: cols_r = d[3:0];
                REG_ALPHA_GAIN:   alpha = d[15:0];
                REG_BETA_GAIN:    beta = d[15:0];
                default: ;
            endcase
        endfunction

        function void note_input(t_action a, logic [2:0] r, logic [2:0] c,
                                 logic signed [15:0] v);
            longint  dot, acc, q;
            t_result res;
            int      nr, nk, nc;
            if (a != ACT_COMPUTE) begin
                mat[int'(a)][r * 8 + c] = v;
                seen[int'(a)][r * 8 + c] = 1;
                return;
            end
            nr = eff(rows_r);
            nk = eff(inner_r);
            nc = eff(cols_r);
            for (int i = 0; i < nr; i++) begin
                for (int j = 0; j < nc; j++) begin
                    dot = 0;
                    for (int k = 0; k < nk; k++)
                        dot += longint'(mat[0][i * 8 + k]) * longint'(mat[1][k * 8 + j]);
                    acc = longint'(alpha) * dot
                        + longint'(beta) * longint'(mat[2][i * 8 + j]) * 256;
                    q = acc >>> 16;
                    if (q > 64'sh7FFF_FFFF) q = 64'sh7FFF_FFFF;
                    if (q < -64'sh8000_0000) q = -64'sh8000_0000;
                    res.row = i[2:0];
                    res.col = j[2:0];
                    res.value = q[31:0];
                    res.last = (i == nr - 1) && (j == nc - 1);
                    due_q.push_back(res);
                end
            end
        endfunction

        function void check(logic [2:0] row, logic [2:0] col, logic [31:0] value,
                            logic last);
            t_result e;
            if (due_q.size() == 0) begin
                $error("unexpected result row=%0d col=%0d value=%0d", row, col,
                       $signed(value));
                errors++;
                return;
            end
            e = due_q.pop_front();
            checked++;
            if (row !== e.row) begin
                $error("out_row: expected %0d, got %0d", e.row, row);
                errors++;
            end
            if (col !== e.col) begin
                $error("out_col: expected %0d, got %0d", e.col, col);
                errors++;
            end
            if (value !== e.value) begin
                $error("out_value: expected %0d, got %0d", $signed(e.value),
                       $signed(value));
                errors++;
            end
            if (last !== e.last) begin
                $error("last_flag: expected %0d, got %0d", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PADDR_W-1:0]       paddr = '0;
    logic [PDATA_W-1:0]       pwdata = '0;
    logic [PDATA_W-1:0]       prdata;
    logic                     pready;
    logic                     push = 1'b0;
    logic                     full;
    logic [1:0]               i_action = '0;
    logic [IDX_W-1:0]         i_row_index = '0;
    logic [IDX_W-1:0]         i_col_index = '0;
    logic signed [ELEM_W-1:0] i_elem_value = '0;
    logic                     empty;
    logic                     pop = 1'b0;
    logic [IDX_W-1:0]         o_out_row;
    logic [IDX_W-1:0]         o_out_col;
    logic signed [OUT_W-1:0]  o_out_value;
    logic                     o_last_flag;

    gemm_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int items_sent;
    int stall_cycles;

    general_matrix_multiply_top dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(negedge i_clk)
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            sb.check(o_out_row, o_out_col, o_out_value, o_last_flag);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic reg_write(int idx, logic [31:0] d);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(4 * idx);
        pwdata <= d;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, d);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send(t_action a, logic [2:0] r, logic [2:0] c, logic [15:0] v);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
        @(negedge i_clk);
        push <= 1'b1;
        i_action <= a;
        i_row_index <= r;
        i_col_index <= c;
        i_elem_value <= v;
        do @(posedge i_clk); while (full);
        sb.note_input(a, r, c, v);
        items_sent++;
    endtask

    function automatic logic [15:0] rand_elem();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic fill_needed();
        int nr, nk, nc;
        nr = sb.eff(sb.rows_r);
        nk = sb.eff(sb.inner_r);
        nc = sb.eff(sb.cols_r);
        for (int i = 0; i < 8; i++) begin
            for (int j = 0; j < 8; j++) begin
                if (i < nr && j < nk && !sb.seen[0][i * 8 + j])
                    send(ACT_WR_A, i[2:0], j[2:0], rand_elem());
                if (i < nk && j < nc && !sb.seen[1][i * 8 + j])
                    send(ACT_WR_B, i[2:0], j[2:0], rand_elem());
                if (i < nr && j < nc && !sb.seen[2][i * 8 + j])
                    send(ACT_WR_C, i[2:0], j[2:0], rand_elem());
            end
        end
    endtask

    task automatic compute();
        fill_needed();
        send(ACT_COMPUTE, 3'($urandom), 3'($urandom), 16'($urandom));
    endtask

    task automatic drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (sb.due_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic configure(int r, int k, int c, int al, int be);
        reg_write(REG_ROW_COUNT, r);
        reg_write(REG_INNER_COUNT, k);
        reg_write(REG_COLUMN_COUNT, c);
        reg_write(REG_ALPHA_GAIN, al);
        reg_write(REG_BETA_GAIN, be);
    endtask

    task automatic random_items(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0)
                compute();
            else
                send(t_action'($urandom_range(0, 2)), 3'($urandom), 3'($urandom),
                     rand_elem());
        end
        compute();
    endtask

    initial begin
        int phase;
        sb = new();
        sb.clear();
        send_idle_pct = 28;
        recv_idle_pct = 68;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: clamped counts, gain extremes, positive saturation
        configure(0, 15, 1, 32767, -32768);
        reg_write(5, 32'hFFFF_FFFF);
        reg_write(7, 32'h1234_5678);
        for (int k = 0; k < 8; k++) begin
            send(ACT_WR_A, 3'd0, 3'(k), 16'h7FFF);
            send(ACT_WR_B, 3'(k), 3'd0, 16'h7FFF);
        end
        send(ACT_WR_C, 3'd0, 3'd0, 16'h8000);
        send(ACT_COMPUTE, 3'd7, 3'd7, 16'hFFFF);
        send(ACT_WR_B, 3'd7, 3'd0, 16'h8000);
        send(ACT_COMPUTE, 3'd0, 3'd0, 16'h0000);
        drain();
        configure(1, 1, 1, -32768, 32767);
        send(ACT_COMPUTE, 3'd5, 3'd2, 16'h5A5A);
        drain();

        for (phase = 0; phase < 6; phase++) begin
            if (phase == 2) begin
                send_idle_pct = 68;
                recv_idle_pct = 28;
            end else if (phase == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            configure($urandom_range(1, 3), $urandom_range(0, 3),
                      $urandom_range(1, 3), $urandom_range(0, 65535),
                      $urandom_range(0, 65535));
            random_items(8);
            drain();
        end

        configure(8, 1, 1, $urandom_range(0, 65535), $urandom_range(0, 65535));
        compute();
        drain();

        $display("testbench: %0d input transactions, %0d result transactions checked",
                 items_sent, sb.checked);
        $display("testbench: clamped and small random sizes, a full-height column, "
                 , "gain extremes, stalls");
        if (sb.errors == 0 && sb.due_q.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
